// ----- src/brle_pkg.sv -----
// Shared types and constants of the byte run-length encoder.
`default_nettype none

package brle_pkg;

   // Longest run or literal block, and coded bytes per result word.
   localparam int MAX_BLOCK        = 127;
   localparam int BYTES_PER_RESULT = 4;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int ADDR_W  = $clog2(MAX_BLOCK);
   localparam int WORD_W  = BYTE_W * BYTES_PER_RESULT;
   localparam int COUNT_W = 3;
   localparam int LANE_W  = $clog2(BYTES_PER_RESULT);

   // Header flag of a repeat block.
   localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;

   // Depth of the command queue between the front and back ends.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Commands issued by the classifier.
   typedef enum logic [1:0] {
      CMD_RUN,
      CMD_LIT,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [LEN_W-1:0]        len;
      logic [BYTE_W-1:0]       data;
      logic                    frame_done;
   } cmd_type;

   // Push side of the command queue.
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_push_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } cmd_head_type;

   // Write port of the literal store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   // One result word.
   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               step_last;
      logic               frame_done;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/brle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module brle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/brle_cmdq.sv -----
// Short command queue between the classifier and the block emitter.
`default_nettype none

module brle_cmdq
   import brle_pkg::*;
(
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  cmd_push_type in_push,
   output logic               full,
   output cmd_head_type       head,
   input  wire  logic         pop
);

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full       = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign head.empty = (cnt_ff == '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   assign do_push = in_push.push && !full;
   assign do_pop  = pop && !head.empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_push.cmd;
      end
   end

endmodule

`default_nettype wire

// ----- src/brle_front.sv -----
// Front end: accepts raw bytes, keeps the lookahead and classifies bytes into blocks.
`default_nettype none

module brle_front
   import brle_pkg::*;
(
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              req_push,
   output logic                    req_full,
   input  wire  logic [BYTE_W-1:0] req_in_byte,
   input  wire  logic              req_frame_last,
   output cmd_push_type            cmd_out,
   input  wire  logic              cmd_full,
   output store_wr_type            store_wr,
   input  wire  logic              lit_done
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_VISIT,
      F_END
   } state_type;

   typedef enum logic [1:0] {
      M_IDLE,
      M_RUN,
      M_LIT
   } mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [LEN_W-1:0]  blen_ff, blen_in;
   logic [BYTE_W-1:0] run_byte_ff, run_byte_in;
   logic [1:0]        fill_ff, fill_in;
   logic [BYTE_W-1:0] la0_ff, la0_in, la1_ff, la1_in;
   logic [BYTE_W-1:0] vq_ff [3];
   logic [BYTE_W-1:0] vq_in [3];
   logic [1:0]        vidx_ff, vidx_in;
   logic [1:0]        vcnt_ff, vcnt_in;
   logic              last_ff, last_in;
   logic              produced_ff, produced_in;
   logic              lit_pending_ff, lit_pending_in;

   logic              accept;
   logic              visit_go;
   logic [BYTE_W-1:0] vb, n1, n2;
   logic              h1, h2;
   logic [LEN_W-1:0]  len1;
   logic              lit_go;

   assign req_full = (state_ff != F_IDLE);
   assign accept   = req_push && !req_full;

   // Bytes seen by the current classification: the byte and its two successors.
   always_comb begin
      vb = '0;
      n1 = '0;
      n2 = '0;
      case (vidx_ff)
         2'd0: begin
            vb = vq_ff[0];
            n1 = vq_ff[1];
            n2 = vq_ff[2];
         end
         2'd1: begin
            vb = vq_ff[1];
            n1 = vq_ff[2];
         end
         2'd2: begin
            vb = vq_ff[2];
         end
         default: begin
            vb = '0;
         end
      endcase
      h1 = !last_ff || ({1'b0, vidx_ff} + 3'd1 < {1'b0, vcnt_ff});
      h2 = !last_ff || ({1'b0, vidx_ff} + 3'd2 < {1'b0, vcnt_ff});
   end

   // A classification waits for room in the queue, and for the literal store
   // to be released when it may write there.
   assign visit_go = (state_ff == F_VISIT) && !cmd_full &&
                     ((mode_ff == M_RUN) || !lit_pending_ff);

   // Literal grows only while the next byte differs from this one and from the one after.
   always_comb begin
      len1   = (mode_ff == M_LIT) ? blen_ff + 1'b1 : LEN_W'(1);
      lit_go = h1 && (vb != n1) && (!h2 || (n1 != n2)) && (len1 < LEN_W'(MAX_BLOCK));
   end

   // Next state of the lookahead, classifier and sequencing.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      blen_in        = blen_ff;
      run_byte_in    = run_byte_ff;
      fill_in        = fill_ff;
      la0_in         = la0_ff;
      la1_in         = la1_ff;
      vq_in          = vq_ff;
      vidx_in        = vidx_ff;
      vcnt_in        = vcnt_ff;
      last_in        = last_ff;
      produced_in    = produced_ff;
      lit_pending_in = lit_pending_ff;
      cmd_out        = '0;
      store_wr       = '0;

      if (lit_done) begin
         lit_pending_in = 1'b0;
      end

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               produced_in = 1'b0;
               vidx_in     = '0;
               last_in     = req_frame_last;
               if (!req_frame_last) begin
                  if (fill_ff == 2'd2) begin
                     vq_in[0] = la0_ff;
                     vq_in[1] = la1_ff;
                     vq_in[2] = req_in_byte;
                     vcnt_in  = 2'd1;
                     la0_in   = la1_ff;
                     la1_in   = req_in_byte;
                     state_in = F_VISIT;
                  end else begin
                     if (fill_ff == 2'd0) begin
                        la0_in = req_in_byte;
                     end else begin
                        la1_in = req_in_byte;
                     end
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  // End of frame: classify every pending byte and the new one.
                  vq_in[0] = la0_ff;
                  vq_in[1] = la1_ff;
                  vq_in[2] = req_in_byte;
                  if (fill_ff == 2'd0) begin
                     vq_in[0] = req_in_byte;
                  end else if (fill_ff == 2'd1) begin
                     vq_in[1] = req_in_byte;
                  end
                  vcnt_in  = fill_ff + 1'b1;
                  la0_in   = '0;
                  la1_in   = '0;
                  fill_in  = '0;
                  state_in = F_VISIT;
               end
            end
         end

         F_VISIT: begin
            if (visit_go) begin
               case (mode_ff)
                  M_RUN: begin
                     if (h1 && (vb == n1) && (blen_ff + 1'b1 < LEN_W'(MAX_BLOCK))) begin
                        blen_in = blen_ff + 1'b1;
                     end else begin
                        cmd_out.push           = 1'b1;
                        cmd_out.cmd.kind       = CMD_RUN;
                        cmd_out.cmd.len        = blen_ff + 1'b1;
                        cmd_out.cmd.data       = run_byte_ff;
                        mode_in                = M_IDLE;
                        blen_in                = '0;
                     end
                  end
                  M_LIT: begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = ADDR_W'(blen_ff);
                     store_wr.data = vb;
                     if (lit_go) begin
                        blen_in = len1;
                     end else begin
                        cmd_out.push     = 1'b1;
                        cmd_out.cmd.kind = CMD_LIT;
                        cmd_out.cmd.len  = len1;
                        mode_in          = M_IDLE;
                        blen_in          = '0;
                        lit_pending_in   = 1'b1;
                     end
                  end
                  default: begin
                     // No open block: start a run on a pair, otherwise a literal.
                     if (h1 && (vb == n1)) begin
                        mode_in     = M_RUN;
                        blen_in     = LEN_W'(1);
                        run_byte_in = vb;
                     end else begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = '0;
                        store_wr.data = vb;
                        if (lit_go) begin
                           mode_in = M_LIT;
                           blen_in = LEN_W'(1);
                        end else begin
                           cmd_out.push     = 1'b1;
                           cmd_out.cmd.kind = CMD_LIT;
                           cmd_out.cmd.len  = LEN_W'(1);
                           mode_in          = M_IDLE;
                           blen_in          = '0;
                           lit_pending_in   = 1'b1;
                        end
                     end
                  end
               endcase

               if (cmd_out.push) begin
                  produced_in = 1'b1;
               end

               // After the last classification of this transfer, mark its end if the transfer produced a command.
               if (vidx_ff == vcnt_ff - 1'b1) begin
                  state_in = (produced_ff || cmd_out.push) ? F_END : F_IDLE;
                  if (last_ff) begin
                     mode_in = M_IDLE;
                     blen_in = '0;
                  end
               end else begin
                  vidx_in = vidx_ff + 1'b1;
               end
            end
         end

         F_END: begin
            if (!cmd_full) begin
               cmd_out.push           = 1'b1;
               cmd_out.cmd.kind       = CMD_END;
               cmd_out.cmd.frame_done = last_ff;
               state_in               = F_IDLE;
            end
         end

         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         mode_ff        <= M_IDLE;
         blen_ff        <= '0;
         fill_ff        <= '0;
         la0_ff         <= '0;
         la1_ff         <= '0;
         vidx_ff        <= '0;
         vcnt_ff        <= '0;
         last_ff        <= 1'b0;
         produced_ff    <= 1'b0;
         lit_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         blen_ff        <= blen_in;
         fill_ff        <= fill_in;
         la0_ff         <= la0_in;
         la1_ff         <= la1_in;
         vidx_ff        <= vidx_in;
         vcnt_ff        <= vcnt_in;
         last_ff        <= last_in;
         produced_ff    <= produced_in;
         lit_pending_ff <= lit_pending_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      vq_ff       <= vq_in;
   end

endmodule

`default_nettype wire

// ----- src/brle_back.sv -----
// Back end: expands commands into coded bytes and packs them into result words.
`default_nettype none

module brle_back
   import brle_pkg::*;
(
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  cmd_head_type       cmd_head,
   output logic                     cmd_pop,
   output logic [ADDR_W-1:0]        store_rd_addr,
   input  wire  logic [BYTE_W-1:0]  store_rd_data,
   output logic                     lit_done,
   output logic                     rsp_empty,
   input  wire  logic               rsp_pop,
   output logic [WORD_W-1:0]        rsp_out_word,
   output logic [COUNT_W-1:0]       rsp_out_count,
   output logic                     rsp_step_last,
   output logic                     rsp_frame_done
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUNB,
      B_LIT
   } state_type;

   state_type          state_ff, state_in;
   logic [BYTE_W-1:0]  run_byte_ff, run_byte_in;
   logic [LEN_W-1:0]   lit_n_ff, lit_n_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   // Two-entry result queue.
   rsp_type            oq_ff [2];
   logic               oq_wr_ff, oq_rd_ff;
   logic [1:0]         oq_cnt_ff;

   logic               go;
   logic               byte_valid;
   logic [BYTE_W-1:0]  byte_val;
   logic               end_flush;
   logic               end_frame;
   logic               emit;
   rsp_type            emit_rsp;
   logic               oq_pop;

   assign go     = (oq_cnt_ff != 2'd2);
   assign oq_pop = rsp_pop && !rsp_empty;

   // Command sequencing: one coded byte per cycle while the result queue has room.
   always_comb begin
      state_in      = state_ff;
      run_byte_in   = run_byte_ff;
      lit_n_in      = lit_n_ff;
      idx_in        = idx_ff;
      cmd_pop       = 1'b0;
      byte_valid    = 1'b0;
      byte_val      = '0;
      end_flush     = 1'b0;
      end_frame     = 1'b0;
      lit_done      = 1'b0;
      store_rd_addr = ADDR_W'(idx_ff);

      case (state_ff)
         B_IDLE: begin
            store_rd_addr = '0;
            idx_in        = '0;
            if (go && !cmd_head.empty) begin
               cmd_pop = 1'b1;
               case (cmd_head.cmd.kind)
                  CMD_RUN: begin
                     byte_valid  = 1'b1;
                     byte_val    = RUN_FLAG | {1'b0, cmd_head.cmd.len};
                     run_byte_in = cmd_head.cmd.data;
                     state_in    = B_RUNB;
                  end
                  CMD_LIT: begin
                     byte_valid = 1'b1;
                     byte_val   = {1'b0, cmd_head.cmd.len};
                     lit_n_in   = cmd_head.cmd.len;
                     state_in   = B_LIT;
                  end
                  CMD_END: begin
                     end_flush = 1'b1;
                     end_frame = cmd_head.cmd.frame_done;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         B_RUNB: begin
            if (go) begin
               byte_valid = 1'b1;
               byte_val   = run_byte_ff;
               state_in   = B_IDLE;
            end
         end

         B_LIT: begin
            // The read data always belongs to the current index.
            if (go) begin
               byte_valid = 1'b1;
               byte_val   = store_rd_data;
               if (idx_ff == lit_n_ff - LEN_W'(1)) begin
                  lit_done = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  idx_in        = idx_ff + 1'b1;
                  store_rd_addr = ADDR_W'(idx_ff + 1'b1);
               end
            end
         end

         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Packing: a full word leaves when the next byte arrives; at the end marker the word leaves as it stands.
   always_comb begin
      word_in  = word_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      emit_rsp = '0;
      if (byte_valid) begin
         if (cnt_ff == COUNT_W'(BYTES_PER_RESULT)) begin
            emit           = 1'b1;
            emit_rsp.word  = word_ff;
            emit_rsp.count = cnt_ff;
            word_in        = WORD_W'(byte_val);
            cnt_in         = COUNT_W'(1);
         end else begin
            word_in[{cnt_ff[LANE_W-1:0], 3'b000} +: BYTE_W] = byte_val;
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (end_flush) begin
         emit                = 1'b1;
         emit_rsp.word       = word_ff;
         emit_rsp.count      = cnt_ff;
         emit_rsp.step_last  = 1'b1;
         emit_rsp.frame_done = end_frame;
         word_in             = '0;
         cnt_in              = '0;
      end
   end

   // Sequencer, packer and result queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         idx_ff    <= '0;
         word_ff   <= '0;
         cnt_ff    <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         word_ff  <= word_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            oq_wr_ff <= !oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= !oq_rd_ff;
         end
         if (emit && !oq_pop) begin
            oq_cnt_ff <= oq_cnt_ff + 1'b1;
         end else if (oq_pop && !emit) begin
            oq_cnt_ff <= oq_cnt_ff - 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      lit_n_ff    <= lit_n_in;
      if (emit) begin
         oq_ff[oq_wr_ff] <= emit_rsp;
      end
   end

   // Result ports show the oldest waiting word.
   assign rsp_empty      = (oq_cnt_ff == 2'd0);
   assign rsp_out_word   = oq_ff[oq_rd_ff].word;
   assign rsp_out_count  = oq_ff[oq_rd_ff].count;
   assign rsp_step_last  = oq_ff[oq_rd_ff].step_last;
   assign rsp_frame_done = oq_ff[oq_rd_ff].frame_done;

endmodule

`default_nettype wire

// ----- src/byte_run_length_encoder.sv -----
// Top level of the byte run-length encoder: front end, command queue, back end and literal store.
// Flow: a byte is classified in F_VISIT after the transfer of its second successor (or of the
//   frame's last byte), once the command queue has room and, for a literal byte, the store is free;
//   its coded bytes follow, one coded byte a cycle while the result queue has room. A new byte is
//   refused until the classifications and end marker of the last transfer are done; a literal holds
//   the back end and stalls the next literal store write until it has been read out.
// Reset: synchronous; clears lookahead, open block, queues and packer; the store needs no clearing.
`default_nettype none

module byte_run_length_encoder
   import brle_pkg::*;
(
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               req_push,
   output logic                     req_full,
   input  wire  logic [BYTE_W-1:0]  req_in_byte,
   input  wire  logic               req_frame_last,
   output logic                     rsp_empty,
   input  wire  logic               rsp_pop,
   output logic [WORD_W-1:0]        rsp_out_word,
   output logic [COUNT_W-1:0]       rsp_out_count,
   output logic                     rsp_step_last,
   output logic                     rsp_frame_done
);

   cmd_push_type      cmd_push;
   cmd_head_type      cmd_head;
   logic              cmd_full;
   logic              cmd_pop;
   store_wr_type      store_wr;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [BYTE_W-1:0] store_rd_data;
   logic              lit_done;

   // Classifier.
   brle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_frame_last (req_frame_last),
      .cmd_out        (cmd_push),
      .cmd_full       (cmd_full),
      .store_wr       (store_wr),
      .lit_done       (lit_done)
   );

   // Command queue.
   brle_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .in_push (cmd_push),
      .full    (cmd_full),
      .head    (cmd_head),
      .pop     (cmd_pop)
   );

   // Bytes of the open literal.
   brle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_BLOCK)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // Block emitter and word packer.
   brle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .store_rd_addr  (store_rd_addr),
      .store_rd_data  (store_rd_data),
      .lit_done       (lit_done),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_word   (rsp_out_word),
      .rsp_out_count  (rsp_out_count),
      .rsp_step_last  (rsp_step_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire
